>>> hw/rtl/hcb_pkg.sv
// hcb_pkg: shared types and constants for the huffman code builder
// no dependencies
package hcb_pkg;

    localparam int SYM_W  = 5;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 31;
    localparam int IN_W   = 16;

    typedef struct packed {
        logic [IN_W-1:0] weight;
        logic            last;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_bits;
        logic              last_code;
    } t_out_item;

endpackage

>>> hw/rtl/hcb_if.sv
// hcb_if: valid/ready channel carrying one payload
// no dependencies; the payload type is set by parameter T
interface hcb_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/hcb_ram.sv
// hcb_ram: generic single write port, single read port ram, registered read
// no dependencies
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/hcb_front.sv
// hcb_front: accepts weights, masks and counts them, queues load/close commands
// depends on hcb_pkg
module hcb_front import hcb_pkg::*; #(
    parameter int MAX_SYMBOLS = 32,
    parameter int WEIGHT_BITS = 16,
    parameter int NW          = $clog2(2*MAX_SYMBOLS),
    parameter int CW          = $clog2(MAX_SYMBOLS+1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_pop,
    output logic                   o_cmd_store,
    output logic                   o_cmd_last,
    output logic [NW-1:0]          o_cmd_idx,
    output logic [WEIGHT_BITS-1:0] o_cmd_weight,
    output logic [CW-1:0]          o_cmd_count
);
    localparam int QD = 2;
    localparam int EW = 1 + 1 + NW + WEIGHT_BITS + CW;

    logic [CW-1:0]  r_cnt, n_cnt;
    logic [EW-1:0]  r_q [QD];
    logic           r_wp, r_rp;
    logic [1:0]     r_lvl;
    logic           push, store;
    logic [WEIGHT_BITS-1:0] wmask;
    logic [EW-1:0]  entry;

    assign o_in_ready = (r_lvl < 2'(QD));
    assign push  = i_in_valid && o_in_ready;
    assign store = (r_cnt < CW'(MAX_SYMBOLS));

    always_comb begin
        wmask = WEIGHT_BITS'(i_in_data.weight);
        n_cnt = r_cnt;
        if (push) begin
            if (i_in_data.last) begin
                n_cnt = '0;
            end else if (store) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
        entry = {store, i_in_data.last, NW'(r_cnt + CW'(1)), wmask,
                 store ? CW'(r_cnt + CW'(1)) : r_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_lvl <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_lvl <= r_lvl + 2'(push) - 2'(i_cmd_pop);
        end
        if (push) begin
            r_q[r_wp] <= entry;
        end
    end

    assign o_cmd_valid = (r_lvl != 2'd0);
    assign {o_cmd_store, o_cmd_last, o_cmd_idx, o_cmd_weight, o_cmd_count} = r_q[r_rp];

    a_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= 2'(QD)) else $error("queue overflow");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_lvl != 2'd0) else $error("pop of empty queue");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_SYMBOLS)) else $error("symbol count overrun");
endmodule

>>> hw/rtl/hcb_back.sv
// hcb_back: node table writes, tree build by scanning, code walk and emission
// depends on hcb_pkg and hcb_ram
module hcb_back import hcb_pkg::*; #(
    parameter int MAX_SYMBOLS = 32,
    parameter int WEIGHT_BITS = 16,
    parameter int NW          = $clog2(2*MAX_SYMBOLS),
    parameter int CW          = $clog2(MAX_SYMBOLS+1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_pop,
    input  logic                   i_cmd_store,
    input  logic                   i_cmd_last,
    input  logic [NW-1:0]          i_cmd_idx,
    input  logic [WEIGHT_BITS-1:0] i_cmd_weight,
    input  logic [CW-1:0]          i_cmd_count,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data
);
    localparam int NS = 2*MAX_SYMBOLS;
    localparam int WW = WEIGHT_BITS + $clog2(MAX_SYMBOLS) + 1;
    localparam int MR = 32;
    localparam int ER = (MAX_SYMBOLS < MR) ? MAX_SYMBOLS : MR;
    localparam int LW = (NW > LEN_W) ? NW : LEN_W + 1;
    localparam int KW = NW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN_W, S_SCAN, S_JOIN, S_JOIN_B, S_WALK_R, S_WALK, S_EMIT
    } t_state;

    t_state            r_st;
    logic [NW-1:0]     r_i, r_j, r_m, r_b1, r_b2, r_c, r_s, r_emit;
    logic              r_f1, r_f2;
    logic [WW-1:0]     r_w1, r_w2;
    logic [LW-1:0]     r_len;
    logic [CODE_W-1:0] r_code;
    logic [NS-1:0]     r_taken, n_taken;

    logic              w_we, k_we;
    logic [NW-1:0]     w_wa, k_wa;
    logic [WW-1:0]     w_wd, w_rd;
    logic [KW-1:0]     k_wd, k_rd;
    logic              cand, lt1, lt2;

    // weight table u_w, and link table u_k whose entry is right-child flag and parent index
    hcb_ram #(.WIDTH(WW), .DEPTH(NS)) u_w (.i_clk, .i_we(w_we), .i_waddr(w_wa),
        .i_wdata(w_wd), .i_raddr(r_j), .o_rdata(w_rd));
    hcb_ram #(.WIDTH(KW), .DEPTH(NS)) u_k (.i_clk, .i_we(k_we), .i_waddr(k_wa),
        .i_wdata(k_wd), .i_raddr(r_c), .o_rdata(k_rd));

    assign o_cmd_pop = i_cmd_valid && (r_st == S_IDLE);

    always_comb begin
        w_we    = 1'b0;
        w_wa    = i_cmd_idx;
        w_wd    = WW'(i_cmd_weight);
        k_we    = 1'b0;
        k_wa    = r_b1;
        k_wd    = {1'b0, r_i};
        n_taken = r_taken;
        case (r_st)
            S_IDLE: begin
                if (o_cmd_pop && i_cmd_store) begin
                    w_we = 1'b1;
                    n_taken[i_cmd_idx] = 1'b0;
                end
            end
            S_JOIN: begin
                w_we = 1'b1;
                w_wa = r_i;
                w_wd = r_w1 + r_w2;
                k_we = 1'b1;
                n_taken[r_b1] = 1'b1;
                n_taken[r_b2] = 1'b1;
                n_taken[r_i]  = 1'b0;
            end
            S_JOIN_B: begin
                k_we = 1'b1;
                k_wa = r_b2;
                k_wd = {1'b1, r_i};
            end
            default: begin
            end
        endcase
    end

    assign cand = !r_taken[r_j];
    assign lt1  = !r_f1 || (w_rd < r_w1);
    assign lt2  = !r_f2 || (w_rd < r_w2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            o_out_valid <= 1'b0;
            r_taken     <= '0;
        end else begin
            r_taken <= n_taken;
            case (r_st)
                S_IDLE: begin
                    if (o_cmd_pop && i_cmd_last && i_cmd_count > CW'(1)) begin
                        r_m    <= (NW'(i_cmd_count) << 1) - NW'(1);
                        r_i    <= NW'(i_cmd_count) + NW'(1);
                        r_j    <= NW'(1);
                        r_f1   <= 1'b0;
                        r_f2   <= 1'b0;
                        r_emit <= (NW'(i_cmd_count) < NW'(ER)) ? NW'(i_cmd_count) : NW'(ER);
                        r_st   <= S_SCAN_W;
                    end
                end
                S_SCAN_W: begin
                    r_st <= S_SCAN;
                end
                S_SCAN: begin
                    if (cand && lt1) begin
                        r_b2 <= r_b1;
                        r_w2 <= r_w1;
                        r_f2 <= r_f1;
                        r_b1 <= r_j;
                        r_w1 <= w_rd;
                        r_f1 <= 1'b1;
                    end else if (cand && lt2) begin
                        r_b2 <= r_j;
                        r_w2 <= w_rd;
                        r_f2 <= 1'b1;
                    end
                    if (r_j == r_i - NW'(1)) begin
                        r_st <= S_JOIN;
                    end else begin
                        r_j  <= r_j + NW'(1);
                        r_st <= S_SCAN_W;
                    end
                end
                S_JOIN: begin
                    r_st <= S_JOIN_B;
                end
                S_JOIN_B: begin
                    if (r_i == r_m) begin
                        r_s    <= NW'(1);
                        r_c    <= NW'(1);
                        r_len  <= '0;
                        r_code <= '0;
                        r_st   <= S_WALK_R;
                    end else begin
                        r_i  <= r_i + NW'(1);
                        r_j  <= NW'(1);
                        r_f1 <= 1'b0;
                        r_f2 <= 1'b0;
                        r_st <= S_SCAN_W;
                    end
                end
                S_WALK_R: begin
                    if (r_c == r_m) begin
                        o_out_data  <= '{symbol: SYM_W'(r_s - NW'(1)),
                                         code_length: LEN_W'(r_len),
                                         code_bits: r_code,
                                         last_code: (r_s == r_emit)};
                        o_out_valid <= 1'b1;
                        r_st        <= S_EMIT;
                    end else begin
                        r_st <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (k_rd[NW] && r_len < LW'(CODE_W)) begin
                        r_code[r_len[LEN_W-1:0]] <= 1'b1;
                    end
                    r_len <= r_len + LW'(1);
                    r_c   <= k_rd[NW-1:0];
                    r_st  <= S_WALK_R;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (r_s == r_emit) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_s    <= r_s + NW'(1);
                            r_c    <= r_s + NW'(1);
                            r_len  <= '0;
                            r_code <= '0;
                            r_st   <= S_WALK_R;
                        end
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while waiting");
    a_vst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_st == S_EMIT) else $error("result valid outside emit");
    a_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_SCAN |-> r_j < r_i) else $error("scan past new node");
    a_join: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_JOIN |-> r_f1 && r_f2 && r_b1 != r_b2) else $error("bad join");
endmodule

>>> hw/rtl/huffman_code_builder_core.sv
// huffman_code_builder_core: top level of the huffman code builder
// depends on hcb_pkg, hcb_if, hcb_front, hcb_back
// throughput: one weight per cycle while back is idle; a two-entry queue precedes the back
// once a closing weight of two or more symbols leaves the queue, the back scans and joins
// nodes into the tree, walks and emits each code, holding on a stalled output; input stalls when queue full
// reset: synchronous active low, clears symbol count, queue and control state
module huffman_code_builder_core import hcb_pkg::*; #(
    parameter int MAX_SYMBOLS = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hcb_if.sink   i_in,
    hcb_if.source o_out
);
    localparam int NW = $clog2(2*MAX_SYMBOLS);
    localparam int CW = $clog2(MAX_SYMBOLS+1);

    logic                   cv, cp, cs, cl;
    logic [NW-1:0]          ci;
    logic [WEIGHT_BITS-1:0] cwt;
    logic [CW-1:0]          cc;

    hcb_front #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
        .i_clk, .i_rst_n, .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_in_data(i_in.data), .o_cmd_valid(cv), .i_cmd_pop(cp), .o_cmd_store(cs),
        .o_cmd_last(cl), .o_cmd_idx(ci), .o_cmd_weight(cwt), .o_cmd_count(cc));

    hcb_back #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cv), .o_cmd_pop(cp), .i_cmd_store(cs),
        .i_cmd_last(cl), .i_cmd_idx(ci), .i_cmd_weight(cwt), .i_cmd_count(cc),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready), .o_out_data(o_out.data));
endmodule
